// ----- sv/irpt_pkg.sv -----
package irpt_pkg;

  // Field widths
  localparam int VALUE_WIDTH  = 63;
  localparam int DIGITS_WIDTH = 7;
  localparam int KIND_WIDTH   = 2;
  localparam int STATUS_WIDTH = 2;

  // Division step counter covers VALUE_WIDTH steps
  localparam int STEP_COUNT_WIDTH = $clog2(VALUE_WIDTH);

  // Power table is indexed by the full digit count field
  localparam int POW_TAB_DEPTH = 2 ** DIGITS_WIDTH;

  // Largest positive value, held in 64 bits for elaboration math
  localparam logic [63:0] VMAX_POS = 64'((65'd1 << (VALUE_WIDTH - 1)) - 65'd1);

  typedef logic [VALUE_WIDTH-1:0] pow_tab_t [0:POW_TAB_DEPTH-1];

  typedef enum logic [KIND_WIDTH-1:0] {
    KIND_FLOOR,
    KIND_CEIL,
    KIND_HALF_AWAY,
    KIND_TRUNC
  } kind_t;

  typedef enum logic [STATUS_WIDTH-1:0] {
    ST_OK,
    ST_POW,
    ST_OVF
  } status_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic step;
    logic adjust;
    logic finish;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic skip_div;
  } dp_flags_t;

  // Build 10^n for every n that stays within the positive range; zero beyond
  function automatic pow_tab_t pow_tab_build();
    pow_tab_t    tab;
    logic [63:0] p;
    logic        ok;
    p  = 64'd1;
    ok = 1'b1;
    for (int i = 0; i < POW_TAB_DEPTH; i++) begin
      tab[i] = ok ? VALUE_WIDTH'(p) : '0;
      if (p > VMAX_POS / 64'd10) begin
        ok = 1'b0;
      end else begin
        p = p * 64'd10;
      end
    end
    return tab;
  endfunction

  // Largest n with 10^n inside the positive range
  function automatic int pow_last_build();
    logic [63:0] p;
    int          last;
    p    = 64'd1;
    last = 0;
    for (int i = 0; i < POW_TAB_DEPTH; i++) begin
      if (p <= VMAX_POS / 64'd10 && last == i) begin
        p    = p * 64'd10;
        last = i + 1;
      end
    end
    return last;
  endfunction

  localparam pow_tab_t POW10_TAB = pow_tab_build();
  localparam int       POW_N_MAX = pow_last_build();

endpackage

// ----- sv/integer_round_to_power_of_ten_top.sv -----
// Sequence: a transaction that divides passes through the divide, adjust and finish
// states before done strobes its result; pass-through and power-error cases skip the divide.
// One transaction at a time: start is accepted only while idle. The bit-serial
// restoring divider retires one quotient bit per cycle; busy drops in the cycle done is high.
// Reset: synchronous active-high rst returns the controller to idle and clears done.
// The receiver cannot stall: each result is valid only in the cycle done is high.
module integer_round_to_power_of_ten_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [irpt_pkg::KIND_WIDTH-1:0]     kind,
  input  logic [irpt_pkg::VALUE_WIDTH-1:0]    value,
  input  logic [irpt_pkg::DIGITS_WIDTH-1:0]   digits,
  output logic                                done,
  output logic [irpt_pkg::VALUE_WIDTH-1:0]    rounded,
  output logic [irpt_pkg::STATUS_WIDTH-1:0]   status
);
  import irpt_pkg::*;

  dp_cmd_t   cmd;
  dp_flags_t flags;

  // Sequencer
  irpt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .flags (flags),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  // Divider and rounding datapath
  irpt_datapath u_datapath (
    .clk     (clk),
    .cmd     (cmd),
    .kind    (kind),
    .value   (value),
    .digits  (digits),
    .flags   (flags),
    .rounded (rounded),
    .status  (status)
  );

endmodule

// ----- sv/irpt_ctrl.sv -----
module irpt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  irpt_pkg::dp_flags_t flags,
  output logic                busy,
  output logic                done,
  output irpt_pkg::dp_cmd_t   cmd
);
  import irpt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_ADJ,
    S_FIN
  } state_t;

  state_t                      state;
  logic [STEP_COUNT_WIDTH-1:0] count;

  // Sequence one transaction: divide (skipped for pass-through and power errors), adjust, finish
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            count <= '0;
            state <= flags.skip_div ? S_ADJ : S_DIV;
          end
        end
        S_DIV: begin
          if (count == STEP_COUNT_WIDTH'(VALUE_WIDTH - 1)) begin
            state <= S_ADJ;
          end else begin
            count <= count + STEP_COUNT_WIDTH'(1);
          end
        end
        S_ADJ: begin
          state <= S_FIN;
        end
        S_FIN: begin
          state <= S_IDLE;
          done  <= 1'b1;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Decode commands from state
  always_comb begin
    busy       = (state != S_IDLE);
    cmd.load   = (state == S_IDLE) && start;
    cmd.step   = (state == S_DIV);
    cmd.adjust = (state == S_ADJ);
    cmd.finish = (state == S_FIN);
  end

`ifndef SYNTH
  a_done_after_fin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_FIN))
    else $error("result strobe without finish cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= STEP_COUNT_WIDTH'(VALUE_WIDTH - 1))
    else $error("division step counter out of range");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.step, cmd.adjust, cmd.finish}))
    else $error("more than one datapath command");
`endif

endmodule

// ----- sv/irpt_datapath.sv -----
module irpt_datapath (
  input  logic                                clk,
  input  irpt_pkg::dp_cmd_t                   cmd,
  input  logic [irpt_pkg::KIND_WIDTH-1:0]     kind,
  input  logic [irpt_pkg::VALUE_WIDTH-1:0]    value,
  input  logic [irpt_pkg::DIGITS_WIDTH-1:0]   digits,
  output irpt_pkg::dp_flags_t                 flags,
  output logic [irpt_pkg::VALUE_WIDTH-1:0]    rounded,
  output logic [irpt_pkg::STATUS_WIDTH-1:0]   status
);
  import irpt_pkg::*;

  localparam int VW = VALUE_WIDTH;
  localparam logic [VW:0] VSIGN_EXT = (VW+1)'(1) << (VW - 1);
  localparam logic [VW:0] VMAX_EXT  = VSIGN_EXT - (VW+1)'(1);

  typedef enum logic [1:0] {
    MODE_PASS,
    MODE_POW,
    MODE_DIV
  } mode_t;

  mode_t                   mode;
  kind_t                   kind_q;
  logic                    neg;
  logic [VW-1:0]           mag;
  logic [VW-1:0]           pow;
  logic [VW-1:0]           dvd;
  logic [VW-1:0]           rem;
  logic [VW:0]             m;

  logic [DIGITS_WIDTH-1:0] n;
  logic                    in_pass;
  logic                    pow_err;
  logic [VW-1:0]           mag_in;
  logic [VW-1:0]           trial;
  logic                    up;
  logic [VW:0]             m_next;
  logic                    ovf;

  // Decode the incoming transaction
  always_comb begin
    n              = '0 - digits;
    in_pass        = !digits[DIGITS_WIDTH-1];
    pow_err        = (n > DIGITS_WIDTH'(POW_N_MAX));
    flags.skip_div = in_pass || pow_err;
    mag_in         = value[VW-1] ? ('0 - value) : value;
  end

  // Restoring division trial; remainder stays below the power of ten
  assign trial = {rem[VW-2:0], dvd[VW-1]};

  // Decide the step, form the snapped magnitude and flag overflow of the adjusted magnitude
  always_comb begin
    case (kind_q)
      KIND_FLOOR:     up = (rem != '0) && neg;
      KIND_CEIL:      up = (rem != '0) && !neg;
      KIND_HALF_AWAY: up = ({rem, 1'b0} >= {1'b0, pow});
      default:        up = 1'b0;
    endcase
    m_next = ({1'b0, mag} - {1'b0, rem}) + (up ? {1'b0, pow} : '0);
    ovf    = neg ? (m > VSIGN_EXT) : (m > VMAX_EXT);
  end

  // Load, divide, adjust and finish
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode   <= in_pass ? MODE_PASS : (pow_err ? MODE_POW : MODE_DIV);
      kind_q <= kind_t'(kind);
      neg    <= value[VW-1];
      mag    <= mag_in;
      dvd    <= mag_in;
      rem    <= '0;
      pow    <= flags.skip_div ? '0 : POW10_TAB[n];
    end
    if (cmd.step) begin
      dvd <= dvd << 1;
      rem <= (trial >= pow) ? (trial - pow) : trial;
    end
    if (cmd.adjust) begin
      m <= (mode == MODE_DIV) ? m_next : {1'b0, mag};
    end
    if (cmd.finish) begin
      unique case (mode)
        MODE_POW: begin
          rounded <= '0;
          status  <= ST_POW;
        end
        MODE_DIV: begin
          if (ovf) begin
            rounded <= '0;
            status  <= ST_OVF;
          end else begin
            rounded <= neg ? ('0 - m[VW-1:0]) : m[VW-1:0];
            status  <= ST_OK;
          end
        end
        default: begin
          rounded <= neg ? ('0 - m[VW-1:0]) : m[VW-1:0];
          status  <= ST_OK;
        end
      endcase
    end
  end

endmodule
